### hw/rtl/go_back_n_sender_window_macros.svh
// Assertion macros for the sender window top level.
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define GBNSW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBNSW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gbnsw_pkg.sv
// Types, codes and constants of the go-back-N sender window.
`default_nettype none

package gbnsw_pkg;

	localparam int SEQ_BITS         = 16;
	localparam int DESC_BITS        = 32;
	localparam int WINDOW_SLOTS_DEF = 8;
	localparam int TIMEOUT_W        = 16;
	localparam int WINDOW_W         = 4;
	localparam int FLIGHT_W         = 4;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(100);
	localparam logic [WINDOW_W-1:0]  WINDOW_RST  = WINDOW_W'(8);

	typedef enum logic [1:0] {
		FUNC_SEND = 2'd0,
		FUNC_ACK  = 2'd1,
		FUNC_TICK = 2'd2,
		FUNC_IDLE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_NEW     = 2'd0,
		KIND_RETX    = 2'd1,
		KIND_REFUSED = 2'd2,
		KIND_STATUS  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT = 1'b0,
		CFG_WINDOW  = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ST_IDLE   = 1'b0,
		ST_REPLAY = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0]           func;
		logic [DESC_BITS-1:0] packet_desc;
		logic [SEQ_BITS-1:0]  ack_next;
	} cmd_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [SEQ_BITS-1:0]  seq_out;
		logic [DESC_BITS-1:0] desc_out;
		logic                 last;
		logic [FLIGHT_W-1:0]  in_flight;
		logic                 timer_running;
	} res_t;

	typedef struct packed {
		logic                busy;
		logic                timer_on;
		logic [SEQ_BITS-1:0] outstanding;
	} ctrl_stat_t;

endpackage

`default_nettype wire

### hw/rtl/gbnsw_slot_mem.sv
// Slot ring memory holding the descriptors of outstanding packets.
`default_nettype none

module gbnsw_slot_mem import gbnsw_pkg::*; #(
	parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [SLOT_W-1:0]    waddr,
	input  wire logic [DESC_BITS-1:0] wdata,
	input  wire logic                 re,
	input  wire logic [SLOT_W-1:0]    raddr,
	output logic      [DESC_BITS-1:0] rdata
);

	logic [DESC_BITS-1:0] mem [WINDOW_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/gbnsw_outbuf.sv
// Two-entry result buffer: an output register with a skid register behind it.
`default_nettype none

module gbnsw_outbuf import gbnsw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t res_d,
	output logic      full,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic take;

	assign take      = out_valid_q && !res_stall;
	assign full      = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// The producer is held off while the skid entry is occupied.
			if (take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/gbnsw_ctrl.sv
// Window control: sequence state, timer, slot pointers and the replay sequencer.
`default_nettype none

module gbnsw_ctrl import gbnsw_pkg::*; #(
	parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	input  wire cmd_t                 cmd,
	output logic                      cmd_stall,
	input  wire logic [TIMEOUT_W-1:0] timeout_ticks,
	input  wire logic [WINDOW_W-1:0]  window_in_use,
	input  wire logic                 obuf_full,
	output logic                      push,
	output res_t                      res_d,
	output logic                      mem_we,
	output logic      [SLOT_W-1:0]    mem_waddr,
	output logic      [DESC_BITS-1:0] mem_wdata,
	output logic                      mem_re,
	output logic      [SLOT_W-1:0]    mem_raddr,
	input  wire logic [DESC_BITS-1:0] mem_rdata,
	output ctrl_stat_t                stat
);

	localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;
	localparam logic [SUM_W-1:0]  SLOTS_SUM  = SUM_W'(WINDOW_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW_SLOTS - 1);
	localparam logic [SEQ_BITS-1:0] SLOTS_SEQ = SEQ_BITS'(WINDOW_SLOTS);

	state_t state_q, state_d;

	logic [SEQ_BITS-1:0]  next_seq_q, next_seq_d;
	logic [SEQ_BITS-1:0]  base_seq_q, base_seq_d;
	logic [SLOT_W-1:0]    next_slot_q, next_slot_d;
	logic [SLOT_W-1:0]    base_slot_q, base_slot_d;
	logic                 timer_on_q, timer_on_d;
	logic [TIMEOUT_W-1:0] timer_count_q, timer_count_d;
	logic [SEQ_BITS-1:0]  rep_seq_q, rep_seq_d;
	logic [SLOT_W-1:0]    rep_slot_q, rep_slot_d;
	logic [CNT_W-1:0]     rep_left_q, rep_left_d;

	logic                 accept;
	logic [SEQ_BITS-1:0]  flight;
	logic [SEQ_BITS-1:0]  flight_after;
	logic [CNT_W-1:0]     win_eff;
	logic                 room;
	logic [SEQ_BITS-1:0]  adv;
	logic                 ack_ok;
	logic [SUM_W-1:0]     slot_sum;
	logic [SLOT_W-1:0]    ack_slot;
	logic [TIMEOUT_W-1:0] count_inc;
	logic [TIMEOUT_W-1:0] limit;
	logic                 expire;
	logic [CNT_W-1:0]     flight_cap;
	logic                 start_replay;
	logic [SLOT_W-1:0]    next_slot_inc;
	logic [SLOT_W-1:0]    rep_slot_inc;
	logic                 rep_step;

	assign cmd_stall = (state_q != ST_IDLE) || obuf_full;
	assign accept    = cmd_valid && !cmd_stall;
	assign flight    = next_seq_q - base_seq_q;

	always_comb begin
		if (window_in_use == '0) begin
			win_eff = CNT_W'(1);
		end else if (CMP_W'(window_in_use) > CMP_W'(WINDOW_SLOTS)) begin
			win_eff = CNT_W'(WINDOW_SLOTS);
		end else begin
			win_eff = CNT_W'(window_in_use);
		end
	end

	assign room   = flight < SEQ_BITS'(win_eff);
	assign adv    = cmd.ack_next - base_seq_q;
	assign ack_ok = (adv != '0) && (adv <= flight);

	// An accepted advance never exceeds the window, so one subtract wraps the slot.
	assign slot_sum = SUM_W'(base_slot_q) + SUM_W'(adv[CNT_W-1:0]);
	assign ack_slot = (slot_sum >= SLOTS_SUM) ? SLOT_W'(slot_sum - SLOTS_SUM)
	                                          : SLOT_W'(slot_sum);

	assign count_inc  = timer_count_q + TIMEOUT_W'(1);
	assign limit      = (timeout_ticks == '0) ? TIMEOUT_W'(1) : timeout_ticks;
	assign expire     = count_inc >= limit;
	assign flight_cap = (flight > SLOTS_SEQ) ? CNT_W'(WINDOW_SLOTS) : flight[CNT_W-1:0];

	assign start_replay = accept && (cmd.func == FUNC_TICK) && timer_on_q && expire &&
	                      (flight_cap != '0);

	assign next_slot_inc = (next_slot_q == SLOT_LAST) ? '0 : next_slot_q + SLOT_W'(1);
	assign rep_slot_inc  = (rep_slot_q == SLOT_LAST) ? '0 : rep_slot_q + SLOT_W'(1);
	assign rep_step      = (state_q == ST_REPLAY) && !obuf_full && (rep_left_q != '0);

	// Next values of the window registers.
	always_comb begin
		next_seq_d    = next_seq_q;
		base_seq_d    = base_seq_q;
		next_slot_d   = next_slot_q;
		base_slot_d   = base_slot_q;
		timer_on_d    = timer_on_q;
		timer_count_d = timer_count_q;
		rep_seq_d     = rep_seq_q;
		rep_slot_d    = rep_slot_q;
		rep_left_d    = rep_left_q;
		if (accept) begin
			case (cmd.func)
				FUNC_SEND: begin
					if (room) begin
						next_seq_d  = next_seq_q + SEQ_BITS'(1);
						next_slot_d = next_slot_inc;
						if (flight == '0) begin
							timer_on_d    = 1'b1;
							timer_count_d = '0;
						end
					end
				end
				FUNC_ACK: begin
					if (ack_ok) begin
						base_seq_d    = cmd.ack_next;
						base_slot_d   = ack_slot;
						timer_count_d = '0;
						timer_on_d    = cmd.ack_next != next_seq_q;
					end
				end
				FUNC_TICK: begin
					if (timer_on_q) begin
						if (expire) begin
							timer_count_d = '0;
							if (flight_cap == '0) begin
								timer_on_d = 1'b0;
							end else begin
								rep_seq_d  = base_seq_q;
								rep_slot_d = base_slot_q;
								rep_left_d = flight_cap - CNT_W'(1);
							end
						end else begin
							timer_count_d = count_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (rep_step) begin
			rep_seq_d  = rep_seq_q + SEQ_BITS'(1);
			rep_slot_d = rep_slot_inc;
			rep_left_d = rep_left_q - CNT_W'(1);
		end
	end

	assign flight_after = next_seq_d - base_seq_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_replay) begin
					state_d = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				if (!obuf_full && (rep_left_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		push              = 1'b0;
		mem_we            = 1'b0;
		mem_waddr         = next_slot_q;
		mem_wdata         = cmd.packet_desc;
		mem_re            = 1'b0;
		mem_raddr         = base_slot_q;
		res_d.kind        = KIND_STATUS;
		res_d.seq_out     = base_seq_d;
		res_d.desc_out    = '0;
		res_d.last        = 1'b1;
		res_d.in_flight   = flight_after[FLIGHT_W-1:0];
		res_d.timer_running = timer_on_d;
		case (state_q)
			ST_IDLE: begin
				push   = accept && !start_replay;
				mem_we = accept && (cmd.func == FUNC_SEND) && room;
				// The first slot of a burst is read as the tick is taken.
				mem_re = start_replay;
				if (cmd.func == FUNC_SEND) begin
					if (room) begin
						res_d.kind     = KIND_NEW;
						res_d.seq_out  = next_seq_q;
						res_d.desc_out = cmd.packet_desc;
					end else begin
						res_d.kind = KIND_REFUSED;
					end
				end
			end
			ST_REPLAY: begin
				push                = !obuf_full;
				mem_re              = rep_step;
				mem_raddr           = rep_slot_inc;
				res_d.kind          = KIND_RETX;
				res_d.seq_out       = rep_seq_q;
				res_d.desc_out      = mem_rdata;
				res_d.last          = rep_left_q == '0;
				res_d.in_flight     = flight[FLIGHT_W-1:0];
				res_d.timer_running = timer_on_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy        = state_q != ST_IDLE;
	assign stat.timer_on    = timer_on_q;
	assign stat.outstanding = flight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			next_seq_q    <= '0;
			base_seq_q    <= '0;
			next_slot_q   <= '0;
			base_slot_q   <= '0;
			timer_on_q    <= 1'b0;
			timer_count_q <= '0;
			rep_left_q    <= '0;
		end else begin
			state_q       <= state_d;
			next_seq_q    <= next_seq_d;
			base_seq_q    <= base_seq_d;
			next_slot_q   <= next_slot_d;
			base_slot_q   <= base_slot_d;
			timer_on_q    <= timer_on_d;
			timer_count_q <= timer_count_d;
			rep_left_q    <= rep_left_d;
		end
	end

	always_ff @(posedge clk) begin
		rep_seq_q  <= rep_seq_d;
		rep_slot_q <= rep_slot_d;
	end

endmodule

`default_nettype wire

### hw/rtl/go_back_n_sender_window.sv
// Top level of the go-back-N sender window with its configuration registers.
//
//  channel  direction  handshake             payload
//  cmd      in         cmd_valid/cmd_stall   cmd_t: func, packet_desc, ack_next
//  res      out        res_valid/res_stall   res_t: kind, seq_out, desc_out, last, ...
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Send, ack, idle and non-expiring tick items go back to back unless output is full.
// An expiring tick replays the outstanding window from the slot memory, one
// retransmit per cycle while the output has room; input stalls until all are resent.
// The slot memory has a registered read, started as the tick is taken.
// Reset clears the sequence state and timer, presets the registers; slot contents stay.
// A stalled result sits in the output register and one more in the skid entry.
`default_nettype none

module go_back_n_sender_window import gbnsw_pkg::*; #(
	parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire cmd_t                  cmd,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_t                       res,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	`include "go_back_n_sender_window_macros.svh"

	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [WINDOW_W-1:0]  window_q;

	logic                 obuf_full;
	logic                 push;
	res_t                 res_d;
	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_waddr;
	logic [DESC_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [SLOT_W-1:0]    mem_raddr;
	logic [DESC_BITS-1:0] mem_rdata;
	ctrl_stat_t           ctrl_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			window_q  <= WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_WINDOW:  window_q  <= cfg_data[WINDOW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gbnsw_ctrl #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_stall    (cmd_stall),
		.timeout_ticks(timeout_q),
		.window_in_use(window_q),
		.obuf_full    (obuf_full),
		.push         (push),
		.res_d        (res_d),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.stat         (ctrl_stat)
	);

	gbnsw_slot_mem #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_slot_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	gbnsw_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res_d    (res_d),
		.full     (obuf_full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// The timer runs exactly while packets are outstanding.
	`GBNSW_ASSERT(a_timer_matches_flight, ctrl_stat.timer_on == (ctrl_stat.outstanding != '0), "timer state disagrees with outstanding count")
	`GBNSW_ASSERT(a_window_bound, ctrl_stat.outstanding <= SEQ_BITS'(WINDOW_SLOTS), "outstanding count exceeds slot ring")
	// No command is taken while a retransmit burst is being replayed.
	`GBNSW_ASSERT(a_busy_stalls_cmd, !ctrl_stat.busy || cmd_stall, "input taken during replay")
	// Within a retransmit burst the next result is ready right after a transfer.
	`GBNSW_ASSERT_NEXT(a_burst_no_gap, res_valid && !res_stall && !res.last, res_valid, "gap inside a retransmit burst")

endmodule

`default_nettype wire
